>>> hdl/rv32ie_pkg.sv
// Package: shared types and encodings of the RV32I execute block.
`timescale 1ns / 1ps
`default_nettype none
package rv32ie_pkg;

    localparam int MEM_WORDS_DEF = 1024;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEM_READ,
        ST_BYTE_REQ,
        ST_BYTE_DATA,
        ST_RS1,
        ST_RS2,
        ST_EXEC,
        ST_LOAD_WB,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        SEQ_FETCH,
        SEQ_LOAD,
        SEQ_STORE
    } seq_mode_t;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_EXEC  = 2'd2;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_ILLEGAL     = 2'd1;
    localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;
    localparam logic [1:0] STATUS_HALTED      = 2'd3;

    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_FENCE  = 7'h0F;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

endpackage
`default_nettype wire

>>> hdl/rv32i_instruction_execute.sv
// Top level: multi-cycle RV32I core with byte-serial memory access.
//
// Usage: beats enter on the s_ channel (s_tuser = action, s_tdata = word_index
// and write_data) and every beat gives exactly one result beat on the m_
// channel. Action 0 stores a memory word, action 1 reads one back, action 2
// fetches and executes one instruction at the program counter.
// The cfg channel loads the 12-bit start address into the program counter;
// write it only while the block is idle.
// Memory is reached one byte per access through a single registered read
// port: the four-byte fetch and each load and store are done a byte at a
// time; register operands are read one per cycle.
// One beat is worked on at a time; s_tready is high in the idle state only.
// The finished result sits in an output register, so the next beat is taken
// while m_tvalid waits on a stalled receiver; a second result waits in the
// done state until the output register drains.
// Reset clears the register file, the program counter and the halt flag;
// memory contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module rv32i_instruction_execute
    import rv32ie_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [11:0]  cfg_data,     // start_address
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [47:0]  s_tdata,      // word_index[9:0], write_data[41:10], zero fill
    input  wire logic [1:0]   s_tuser,      // action
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata       // pc_after, status, dest_written, dest_reg,
                                            // dest_value, read_data
);

    localparam int AW = $clog2(MEM_WORDS);

    state_t      state_reg, state_next;
    seq_mode_t   mode_reg, mode_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [1:0]  last_reg, last_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] ins_reg, ins_next;
    logic [31:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [31:0] pc_reg, pc_next;
    logic        halt_reg, halt_next;

    logic [1:0]  res_status_reg, res_status_next;
    logic        res_dw_reg, res_dw_next;
    logic [4:0]  res_rd_reg, res_rd_next;
    logic [31:0] res_val_reg, res_val_next;
    logic [31:0] res_rdata_reg, res_rdata_next;

    logic         out_valid_reg, out_valid_next;
    logic [103:0] out_data_reg, out_data_next;

    logic [31:0]   mem [MEM_WORDS];
    logic [31:0]   mem_q_reg;
    logic [AW-1:0] mem_raddr, mem_waddr;
    logic          mem_we;
    logic [31:0]   mem_wdata;

    logic [31:0] rf [32];
    logic [31:0] rf_valid_reg, rf_valid_next;
    logic [31:0] rf_q_reg;
    logic [4:0]  rf_raddr;
    logic        rf_we;
    logic [31:0] rf_wdata;

    logic          accept;
    logic [1:0]    action;
    logic [AW-1:0] widx;
    logic [31:0]   wdata;

    logic [31:0]   seq_addr;
    logic [AW-1:0] seq_word;
    logic [1:0]    seq_off;
    logic [7:0]    mem_byte;
    logic [7:0]    st_byte;
    logic [31:0]   merged;
    logic [31:0]   acc_merged;
    logic          seq_end;

    logic [6:0]  op;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] b_op;
    logic [31:0] imm_i, imm_s, imm_b, imm_j;
    logic [31:0] alu_b;
    logic [4:0]  shamt;
    logic [31:0] alu_val;
    logic        alu_bad;
    logic        is_reg;

    logic [1:0]  ex_status;
    logic        ex_has_rd;
    logic [31:0] ex_val;
    logic [31:0] ex_next_pc;
    logic        ex_take;
    logic [31:0] ld_val;
    logic        load_out;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign accept = s_tvalid && s_tready;
    assign action = s_tuser;
    assign widx   = AW'(s_tdata[9:0]);
    assign wdata  = s_tdata[41:10];

    // byte-serial access path
    assign seq_addr   = base_reg + 32'(cnt_reg);
    assign seq_word   = seq_addr[AW+1:2];
    assign seq_off    = seq_addr[1:0];
    assign mem_byte   = 8'(mem_q_reg >> {seq_off, 3'b000});
    assign st_byte    = 8'(b_reg >> {cnt_reg, 3'b000});
    assign merged     = (mem_q_reg & ~(32'hFF << {seq_off, 3'b000}))
                      | (32'(st_byte) << {seq_off, 3'b000});
    assign acc_merged = acc_reg | (32'(mem_byte) << {cnt_reg, 3'b000});
    assign seq_end    = (cnt_reg == last_reg);

    assign op    = ins_reg[6:0];
    assign rd    = ins_reg[11:7];
    assign f3    = ins_reg[14:12];
    assign f7    = ins_reg[31:25];
    assign b_op  = rf_q_reg;
    assign imm_i = {{20{ins_reg[31]}}, ins_reg[31:20]};
    assign imm_s = {{20{ins_reg[31]}}, ins_reg[31:25], ins_reg[11:7]};
    assign imm_b = {{19{ins_reg[31]}}, ins_reg[31], ins_reg[7], ins_reg[30:25],
                    ins_reg[11:8], 1'b0};
    assign imm_j = {{11{ins_reg[31]}}, ins_reg[31], ins_reg[19:12], ins_reg[20],
                    ins_reg[30:21], 1'b0};

    assign is_reg = (op == OP_REG);
    assign alu_b  = is_reg ? b_op : imm_i;
    assign shamt  = is_reg ? b_op[4:0] : ins_reg[24:20];

    // shared ALU for immediate and register ops
    always_comb
    begin
        alu_bad = 1'b0;
        case (f3)
            3'd0:
            begin
                alu_val = (is_reg && f7 == F7_ALT) ? a_reg - alu_b : a_reg + alu_b;
            end
            3'd1:
            begin
                alu_val = a_reg << shamt;
                alu_bad = !is_reg && f7 != F7_BASE;
            end
            3'd2:    alu_val = {31'd0, $signed(a_reg) < $signed(alu_b)};
            3'd3:    alu_val = {31'd0, a_reg < alu_b};
            3'd4:    alu_val = a_reg ^ alu_b;
            3'd5:
            begin
                alu_val = (f7 == F7_ALT) ? 32'($signed(a_reg) >>> shamt) : a_reg >> shamt;
                alu_bad = f7 != F7_BASE && f7 != F7_ALT;
            end
            3'd6:    alu_val = a_reg | alu_b;
            default: alu_val = a_reg & alu_b;
        endcase
        if (is_reg && ((f7 != F7_BASE && f7 != F7_ALT)
                       || (f7 == F7_ALT && f3 != 3'd0 && f3 != 3'd5)))
        begin
            alu_bad = 1'b1;
        end
    end

    always_comb
    begin
        case (f3)
            3'd0:    ex_take = a_reg == b_op;
            3'd1:    ex_take = a_reg != b_op;
            3'd4:    ex_take = $signed(a_reg) < $signed(b_op);
            3'd5:    ex_take = !($signed(a_reg) < $signed(b_op));
            3'd6:    ex_take = a_reg < b_op;
            default: ex_take = a_reg >= b_op;
        endcase
    end

    // decode of every opcode and execute of non-memory instructions
    always_comb
    begin
        ex_status  = STATUS_OK;
        ex_has_rd  = 1'b0;
        ex_val     = '0;
        ex_next_pc = pc_reg + 32'd4;
        case (op)
            OP_LUI:
            begin
                ex_val    = {ins_reg[31:12], 12'd0};
                ex_has_rd = 1'b1;
            end
            OP_AUIPC:
            begin
                ex_val    = pc_reg + {ins_reg[31:12], 12'd0};
                ex_has_rd = 1'b1;
            end
            OP_JAL:
            begin
                ex_val     = pc_reg + 32'd4;
                ex_next_pc = pc_reg + imm_j;
                ex_has_rd  = 1'b1;
            end
            OP_JALR:
            begin
                ex_val     = pc_reg + 32'd4;
                ex_next_pc = (a_reg + imm_i) & ~32'd1;
                ex_has_rd  = 1'b1;
                if (f3 != 3'd0)
                begin
                    ex_status = STATUS_ILLEGAL;
                end
            end
            OP_BRANCH:
            begin
                if (f3 == 3'd2 || f3 == 3'd3)
                begin
                    ex_status = STATUS_ILLEGAL;
                end
                else if (ex_take)
                begin
                    ex_next_pc = pc_reg + imm_b;
                end
            end
            OP_LOAD:
            begin
                if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7)
                begin
                    ex_status = STATUS_ILLEGAL;
                end
            end
            OP_STORE:
            begin
                if (f3 > 3'd2)
                begin
                    ex_status = STATUS_ILLEGAL;
                end
            end
            OP_IMM, OP_REG:
            begin
                ex_val    = alu_val;
                ex_has_rd = 1'b1;
                if (alu_bad)
                begin
                    ex_status = STATUS_ILLEGAL;
                end
            end
            OP_FENCE, OP_SYSTEM: ex_status = STATUS_UNSUPPORTED;
            default:             ex_status = STATUS_ILLEGAL;
        endcase
    end

    always_comb
    begin
        case (f3)
            3'd0:    ld_val = {{24{acc_reg[7]}}, acc_reg[7:0]};
            3'd1:    ld_val = {{16{acc_reg[15]}}, acc_reg[15:0]};
            3'd4:    ld_val = {24'd0, acc_reg[7:0]};
            3'd5:    ld_val = {16'd0, acc_reg[15:0]};
            default: ld_val = acc_reg;
        endcase
    end

    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_READ)
                    begin
                        state_next = ST_MEM_READ;
                    end
                    else if (action == ACT_EXEC && !halt_reg)
                    begin
                        state_next = ST_BYTE_REQ;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MEM_READ:  state_next = ST_DONE;
            ST_BYTE_REQ:  state_next = ST_BYTE_DATA;
            ST_BYTE_DATA:
            begin
                if (!seq_end)
                begin
                    state_next = ST_BYTE_REQ;
                end
                else if (mode_reg == SEQ_FETCH)
                begin
                    state_next = ST_RS1;
                end
                else if (mode_reg == SEQ_LOAD)
                begin
                    state_next = ST_LOAD_WB;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RS1:       state_next = ST_RS2;
            ST_RS2:       state_next = ST_EXEC;
            ST_EXEC:
            begin
                if (ex_status == STATUS_OK && (op == OP_LOAD || op == OP_STORE))
                begin
                    state_next = ST_BYTE_REQ;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_LOAD_WB:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and control outputs
    always_comb
    begin
        mode_next       = mode_reg;
        cnt_next        = cnt_reg;
        last_next       = last_reg;
        base_next       = base_reg;
        acc_next        = acc_reg;
        ins_next        = ins_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        pc_next         = pc_reg;
        halt_next       = halt_reg;
        res_status_next = res_status_reg;
        res_dw_next     = res_dw_reg;
        res_rd_next     = res_rd_reg;
        res_val_next    = res_val_reg;
        res_rdata_next  = res_rdata_reg;
        rf_valid_next   = rf_valid_reg;
        mem_raddr       = seq_word;
        mem_we          = 1'b0;
        mem_waddr       = seq_word;
        mem_wdata       = merged;
        rf_raddr        = (state_reg == ST_RS1) ? ins_reg[19:15] : ins_reg[24:20];
        rf_we           = 1'b0;
        rf_wdata        = ex_val;

        case (state_reg)
            ST_IDLE:
            begin
                mem_raddr = widx;
                mem_waddr = widx;
                mem_wdata = wdata;
                if (accept)
                begin
                    res_status_next = STATUS_OK;
                    res_dw_next     = 1'b0;
                    res_rd_next     = '0;
                    res_val_next    = '0;
                    res_rdata_next  = '0;
                    mem_we          = (action == ACT_WRITE);
                    if (action == ACT_EXEC)
                    begin
                        if (halt_reg)
                        begin
                            res_status_next = STATUS_HALTED;
                        end
                        mode_next = SEQ_FETCH;
                        base_next = pc_reg;
                        cnt_next  = '0;
                        last_next = 2'd3;
                        acc_next  = '0;
                    end
                end
            end
            ST_MEM_READ:  res_rdata_next = mem_q_reg;
            ST_BYTE_DATA:
            begin
                acc_next = acc_merged;
                cnt_next = cnt_reg + 2'd1;
                if (mode_reg == SEQ_STORE)
                begin
                    mem_we = 1'b1;
                    if (seq_end)
                    begin
                        pc_next = pc_reg + 32'd4;
                    end
                end
                if (mode_reg == SEQ_FETCH && seq_end)
                begin
                    ins_next = acc_merged;
                end
            end
            ST_RS2:       a_next = rf_q_reg;
            ST_EXEC:
            begin
                b_next   = b_op;
                cnt_next = '0;
                acc_next = '0;
                case (f3[1:0])
                    2'd0:    last_next = 2'd0;
                    2'd1:    last_next = 2'd1;
                    default: last_next = 2'd3;
                endcase
                if (ex_status != STATUS_OK)
                begin
                    res_status_next = ex_status;
                    halt_next       = 1'b1;
                end
                else if (op == OP_LOAD)
                begin
                    mode_next = SEQ_LOAD;
                    base_next = a_reg + imm_i;
                end
                else if (op == OP_STORE)
                begin
                    mode_next = SEQ_STORE;
                    base_next = a_reg + imm_s;
                end
                else
                begin
                    pc_next = ex_next_pc;
                    if (ex_has_rd && rd != 5'd0)
                    begin
                        rf_we             = 1'b1;
                        rf_valid_next[rd] = 1'b1;
                        res_dw_next       = 1'b1;
                        res_rd_next       = rd;
                        res_val_next      = ex_val;
                    end
                end
            end
            ST_LOAD_WB:
            begin
                rf_wdata = ld_val;
                pc_next  = pc_reg + 32'd4;
                if (rd != 5'd0)
                begin
                    rf_we             = 1'b1;
                    rf_valid_next[rd] = 1'b1;
                    res_dw_next       = 1'b1;
                    res_rd_next       = rd;
                    res_val_next      = ld_val;
                end
            end
            default:
            begin
            end
        endcase

        if (cfg_valid && cfg_ready)
        begin
            pc_next = {20'd0, cfg_data};
        end

        out_valid_next = (out_valid_reg && !m_tready) || load_out;
        out_data_next  = out_data_reg;
        if (load_out)
        begin
            out_data_next = {res_rdata_reg, res_val_reg, res_rd_reg, res_dw_reg,
                             res_status_reg, pc_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= SEQ_FETCH;
            cnt_reg       <= '0;
            last_reg      <= '0;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            rf_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            pc_reg        <= pc_next;
            halt_reg      <= halt_next;
            rf_valid_reg  <= rf_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg       <= base_next;
        acc_reg        <= acc_next;
        ins_reg        <= ins_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        res_status_reg <= res_status_next;
        res_dw_reg     <= res_dw_next;
        res_rd_reg     <= res_rd_next;
        res_val_reg    <= res_val_next;
        res_rdata_reg  <= res_rdata_next;
        out_data_reg   <= out_data_next;
    end

    // main memory, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= mem[mem_raddr];
    end

    // register file; an entry never written reads as zero
    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf[rd] <= rf_wdata;
        end
        rf_q_reg <= rf_valid_reg[rf_raddr] ? rf[rf_raddr] : 32'd0;
    end

endmodule
`default_nettype wire

>>> test/tb.sv
// Testbench: checks the RV32I execute block against an in-bench predictor.
`timescale 1ns / 1ps
module tb;
    import rv32ie_pkg::*;

    localparam int MEM_BYTES = MEM_WORDS_DEF * 4;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [31:0] pc_after;
        logic [1:0]  status;
        logic        dest_written;
        logic [4:0]  dest_reg;
        logic [31:0] dest_value;
        logic [31:0] read_data;
    } result_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [11:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [47:0]  s_tdata;      // word_index[9:0], write_data[41:10], zero fill
    logic [1:0]   s_tuser;      // action
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;      // pc_after, status, dest_written, dest_reg,
                                // dest_value, read_data

    // architectural copy of the core
    logic [31:0] arch_regs [32];
    logic [31:0] arch_mem [MEM_WORDS_DEF];
    logic [31:0] arch_pc;
    logic [1:0]  halt_code;

    result_t pending_results [$];
    int      error_count;
    int      cycle_count;
    bit      gaps_on;
    int      stall_left;

    rv32i_instruction_execute u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------- encoders ----------------
    function automatic logic [31:0] enc_i(logic [6:0] op, logic [4:0] rd, logic [2:0] f3,
                                          logic [4:0] rs1, logic [11:0] imm);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, OP_REG};
    endfunction

    function automatic logic [31:0] enc_s(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                          logic [11:0] imm);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    function automatic logic [31:0] enc_b(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                          logic [12:0] imm);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
    endfunction

    function automatic logic [31:0] enc_u(logic [6:0] op, logic [4:0] rd, logic [19:0] imm);
        return {imm, rd, op};
    endfunction

    function automatic logic [31:0] enc_j(logic [4:0] rd, logic [20:0] imm);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
    endfunction

    // ---------------- predictor ----------------
    function automatic logic [31:0] mem_bytes_get(logic [31:0] addr, int n);
        logic [31:0] v;
        logic [11:0] a;
        v = '0;
        for (int i = 0; i < n; i++)
        begin
            a = 12'(addr + i);
            v[8*i +: 8] = arch_mem[a[11:2]][8*a[1:0] +: 8];
        end
        return v;
    endfunction

    function automatic void mem_bytes_put(logic [31:0] addr, logic [31:0] v, int n);
        logic [11:0] a;
        for (int i = 0; i < n; i++)
        begin
            a = 12'(addr + i);
            arch_mem[a[11:2]][8*a[1:0] +: 8] = v[8*i +: 8];
        end
    endfunction

    function automatic void execute_insn(ref result_t r);
        logic [31:0] ins, a, b, val, nxt, imm_i, imm_s, imm_b, imm_j, addr;
        logic [6:0]  op, f7;
        logic [2:0]  f3;
        logic [4:0]  rd;
        logic [1:0]  st;
        bit          has_rd, take, do_store;
        ins = mem_bytes_get(arch_pc, 4);
        op = ins[6:0];
        rd = ins[11:7];
        f3 = ins[14:12];
        f7 = ins[31:25];
        a = arch_regs[ins[19:15]];
        b = arch_regs[ins[24:20]];
        imm_i = {{20{ins[31]}}, ins[31:20]};
        imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        nxt = arch_pc + 32'd4;
        val = '0;
        has_rd = 0;
        take = 0;
        do_store = 0;
        st = STATUS_OK;
        addr = a + imm_i;
        case (op)
            OP_LUI:
            begin
                val = {ins[31:12], 12'b0};
                has_rd = 1;
            end
            OP_AUIPC:
            begin
                val = arch_pc + {ins[31:12], 12'b0};
                has_rd = 1;
            end
            OP_JAL:
            begin
                val = nxt;
                nxt = arch_pc + imm_j;
                has_rd = 1;
            end
            OP_JALR:
            begin
                if (f3 != 3'd0)
                    st = STATUS_ILLEGAL;
                val = nxt;
                nxt = (a + imm_i) & ~32'd1;
                has_rd = 1;
            end
            OP_BRANCH:
            begin
                case (f3)
                    3'd0: take = (a == b);
                    3'd1: take = (a != b);
                    3'd4: take = ($signed(a) < $signed(b));
                    3'd5: take = !($signed(a) < $signed(b));
                    3'd6: take = (a < b);
                    3'd7: take = (a >= b);
                    default: st = STATUS_ILLEGAL;
                endcase
                if (take)
                    nxt = arch_pc + imm_b;
            end
            OP_LOAD:
            begin
                case (f3)
                    3'd0:
                    begin
                        val = mem_bytes_get(addr, 1);
                        val = {{24{val[7]}}, val[7:0]};
                    end
                    3'd1:
                    begin
                        val = mem_bytes_get(addr, 2);
                        val = {{16{val[15]}}, val[15:0]};
                    end
                    3'd2: val = mem_bytes_get(addr, 4);
                    3'd4: val = mem_bytes_get(addr, 1);
                    3'd5: val = mem_bytes_get(addr, 2);
                    default: st = STATUS_ILLEGAL;
                endcase
                has_rd = 1;
            end
            OP_STORE:
            begin
                if (f3 > 3'd2)
                    st = STATUS_ILLEGAL;
                do_store = 1;
            end
            OP_IMM:
            begin
                case (f3)
                    3'd0: val = a + imm_i;
                    3'd2: val = ($signed(a) < $signed(imm_i)) ? 32'd1 : 32'd0;
                    3'd3: val = (a < imm_i) ? 32'd1 : 32'd0;
                    3'd4: val = a ^ imm_i;
                    3'd6: val = a | imm_i;
                    3'd7: val = a & imm_i;
                    3'd1:
                    begin
                        if (f7 != F7_BASE)
                            st = STATUS_ILLEGAL;
                        val = a << ins[24:20];
                    end
                    default:
                    begin
                        if (f7 == F7_BASE)
                            val = a >> ins[24:20];
                        else if (f7 == F7_ALT)
                            val = $signed(a) >>> ins[24:20];
                        else
                            st = STATUS_ILLEGAL;
                    end
                endcase
                has_rd = 1;
            end
            OP_REG:
            begin
                if ((f7 == F7_ALT && f3 != 3'd0 && f3 != 3'd5)
                        || (f7 != F7_BASE && f7 != F7_ALT))
                    st = STATUS_ILLEGAL;
                case (f3)
                    3'd0: val = (f7 != F7_BASE) ? a - b : a + b;
                    3'd1: val = a << b[4:0];
                    3'd2: val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                    3'd3: val = (a < b) ? 32'd1 : 32'd0;
                    3'd4: val = a ^ b;
                    3'd5:
                    begin
                        if (f7 != F7_BASE)
                            val = $signed(a) >>> b[4:0];
                        else
                            val = a >> b[4:0];
                    end
                    3'd6: val = a | b;
                    default: val = a & b;
                endcase
                has_rd = 1;
            end
            OP_FENCE, OP_SYSTEM: st = STATUS_UNSUPPORTED;
            default: st = STATUS_ILLEGAL;
        endcase
        r.status = st;
        halt_code = st;
        if (st != STATUS_OK)
            return;
        if (do_store)
            mem_bytes_put(a + imm_s, b, 1 << f3);
        if (has_rd && rd != 5'd0)
        begin
            arch_regs[rd] = val;
            r.dest_written = 1'b1;
            r.dest_reg = rd;
            r.dest_value = val;
        end
        arch_pc = nxt;
    endfunction

    function automatic void retire_beat(logic [1:0] action, logic [9:0] widx,
                                        logic [31:0] wdata);
        result_t r;
        r = '{default: '0};
        if (action == ACT_WRITE)
            arch_mem[widx] = wdata;
        else if (action == ACT_READ)
            r.read_data = arch_mem[widx];
        else if (action == ACT_EXEC)
        begin
            if (halt_code != STATUS_OK)
                r.status = STATUS_HALTED;
            else
                execute_insn(r);
        end
        r.pc_after = arch_pc;
        pending_results.push_back(r);
    endfunction

    // ---------------- driving ----------------
    task automatic send_beat(logic [1:0] action, logic [9:0] widx, logic [31:0] wdata);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = action;
        s_tdata = {6'b0, wdata, widx};
        do
            @(posedge clk);
        while (!s_tready);
        retire_beat(action, widx, wdata);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // write the instruction into the bytes at the program counter, then run it
    task automatic run_insn(logic [31:0] ins);
        logic [11:0] a;
        logic [9:0]  w;
        logic [9:0]  first_w;
        logic [31:0] word;
        first_w = arch_pc[11:2];
        for (int k = 0; k < 2; k++)
        begin
            w = (k == 0) ? first_w : 10'((arch_pc + 32'd3) >> 2);
            if (k == 1 && w == first_w)
                break;
            word = arch_mem[w];
            for (int i = 0; i < 4; i++)
            begin
                a = 12'(arch_pc + i);
                if (a[11:2] == w)
                    word[8*a[1:0] +: 8] = ins[8*i +: 8];
            end
            send_beat(ACT_WRITE, w, word);
        end
        send_beat(ACT_EXEC, 10'($urandom), $urandom);
    endtask

    task automatic drain_results();
        wait (pending_results.size() == 0);
        repeat (30) @(negedge clk);
    endtask

    task automatic write_start(logic [11:0] value);
        drain_results();
        cfg_valid = 1'b1;
        cfg_data = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        arch_pc = {20'b0, value};
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] random_insn();
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3;
        logic [11:0] imm;
        rd = $urandom;
        rs1 = $urandom;
        rs2 = $urandom;
        imm = $urandom;
        case ($urandom_range(0, 9))
            0: return enc_u(OP_LUI, rd, 20'($urandom));
            1: return enc_u(OP_AUIPC, rd, 20'($urandom));
            2: return enc_j(rd, 21'($urandom));
            3: return enc_i(OP_JALR, rd, 3'd0, rs1, imm);
            4:
            begin
                do
                    f3 = $urandom;
                while (f3 == 3'd2 || f3 == 3'd3);
                return enc_b(f3, rs1, rs2, 13'($urandom));
            end
            5:
            begin
                do
                    f3 = $urandom;
                while (f3 == 3'd3 || f3 > 3'd5);
                return enc_i(OP_LOAD, rd, f3, rs1, imm);
            end
            6: return enc_s(3'($urandom_range(0, 2)), rs1, rs2, imm);
            7:
            begin
                f3 = $urandom;
                if (f3 == 3'd1)
                    imm[11:5] = F7_BASE;
                else if (f3 == 3'd5)
                    imm[11:5] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
                return enc_i(OP_IMM, rd, f3, rs1, imm);
            end
            default:
            begin
                f3 = $urandom;
                return enc_r((f3 == 3'd0 || f3 == 3'd5) && $urandom_range(0, 1)
                             ? F7_ALT : F7_BASE, rs2, rs1, f3, rd);
            end
        endcase
    endfunction

    task automatic random_mix(int count);
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 9))
                0: send_beat(ACT_WRITE, 10'($urandom), $urandom);
                1: send_beat(ACT_READ, 10'($urandom), $urandom);
                2: send_beat(2'd3, 10'($urandom), $urandom);
                default: run_insn(random_insn());
            endcase
        end
    endtask

    // ---------------- tests ----------------
    task automatic test_preload();
        for (int w = 0; w < MEM_WORDS_DEF; w++)
            send_beat(ACT_WRITE, 10'(w), $urandom);
    endtask

    task automatic test_directed();
        run_insn(enc_u(OP_LUI, 5'd1, 20'h80000));
        run_insn(enc_i(OP_IMM, 5'd2, 3'd0, 5'd0, 12'hFFF));
        run_insn(enc_i(OP_IMM, 5'd0, 3'd0, 5'd2, 12'h005));      // x0 stays zero
        run_insn(enc_i(OP_IMM, 5'd3, 3'd2, 5'd1, 12'h000));
        run_insn(enc_i(OP_IMM, 5'd4, 3'd3, 5'd2, 12'hFFF));
        run_insn(enc_i(OP_IMM, 5'd5, 3'd5, 5'd1, {F7_ALT, 5'd31}));
        run_insn(enc_i(OP_IMM, 5'd6, 3'd5, 5'd1, {F7_BASE, 5'd31}));
        run_insn(enc_r(F7_ALT, 5'd2, 5'd0, 3'd0, 5'd7));
        run_insn(enc_r(F7_ALT, 5'd2, 5'd1, 3'd5, 5'd8));
        run_insn(enc_s(3'd2, 5'd0, 5'd1, 12'h0FF));              // misaligned word store
        run_insn(enc_i(OP_LOAD, 5'd9, 3'd0, 5'd0, 12'h102));
        run_insn(enc_i(OP_LOAD, 5'd10, 3'd5, 5'd0, 12'h101));
        run_insn(enc_i(OP_LOAD, 5'd11, 3'd2, 5'd2, 12'h000));    // starts at the top byte, wraps
        run_insn(enc_b(3'd5, 5'd1, 5'd0, 13'h1FFE));
        run_insn(enc_i(OP_JALR, 5'd12, 3'd0, 5'd0, 12'h203));    // odd target, bit 0 dropped
        run_insn(enc_j(5'd13, 21'h00002));                       // half-word aligned pc
        send_beat(ACT_READ, 10'h3FF, 32'hFFFF_FFFF);
        send_beat(2'd3, 10'h000, 32'h0);
    endtask

    task automatic test_start_address();
        write_start(12'd4092);
        random_mix(15);
        write_start(12'hFFF);                                    // fetch wraps the memory end
        random_mix(15);
        write_start(12'($urandom));
        random_mix(15);
        write_start(12'd0);
        random_mix(10);
    endtask

    task automatic test_random_stream();
        random_mix(120);
        drain_results();
        random_mix(100);
    endtask

    task automatic test_no_gaps();
        gaps_on = 0;
        random_mix(80);
    endtask

    task automatic test_halt();
        run_insn($urandom_range(0, 1) ? enc_i(OP_SYSTEM, 5'd0, 3'd0, 5'd0, 12'h000)
                                      : enc_r(7'h01, 5'd3, 5'd2, 3'd0, 5'd1));
        send_beat(ACT_EXEC, 10'd0, 32'd0);
        send_beat(ACT_WRITE, 10'd5, 32'hA5A5_5A5A);
        send_beat(ACT_READ, 10'd5, 32'd0);
        send_beat(ACT_EXEC, 10'd0, 32'd0);
    endtask

    // ---------------- receiver and checker ----------------
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 3);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        result_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("rv32i_instruction_execute: mismatch");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                error_count <= error_count + 1;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.pc_after)
                    $error("pc_after: expected %h, got %h", want.pc_after, m_tdata[31:0]);
                if (m_tdata[33:32] !== want.status)
                    $error("status: expected %0d, got %0d", want.status, m_tdata[33:32]);
                if (m_tdata[34] !== want.dest_written)
                    $error("dest_written: expected %0d, got %0d", want.dest_written,
                           m_tdata[34]);
                if (m_tdata[39:35] !== want.dest_reg)
                    $error("dest_reg: expected %0d, got %0d", want.dest_reg, m_tdata[39:35]);
                if (m_tdata[71:40] !== want.dest_value)
                    $error("dest_value: expected %h, got %h", want.dest_value,
                           m_tdata[71:40]);
                if (m_tdata[103:72] !== want.read_data)
                    $error("read_data: expected %h, got %h", want.read_data,
                           m_tdata[103:72]);
                if (m_tdata !== {want.read_data, want.dest_value, want.dest_reg,
                                 want.dest_written, want.status, want.pc_after})
                    error_count <= error_count + 1;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        stall_left = 0;
        error_count = 0;
        cycle_count = 0;
        gaps_on = 1;
        arch_pc = '0;
        halt_code = STATUS_OK;
        for (int i = 0; i < 32; i++)
            arch_regs[i] = '0;
        for (int i = 0; i < MEM_WORDS_DEF; i++)
            arch_mem[i] = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_preload();
        test_directed();
        test_start_address();
        test_random_stream();
        test_no_gaps();
        test_halt();

        wait (pending_results.size() == 0);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("rv32i_instruction_execute: match");
        else
            $display("rv32i_instruction_execute: mismatch");
        $finish;
    end

endmodule
